>>> sv/sorted_insert_priority_queue_macros.svh
// assertion macros for the sorted insert priority queue
// users need clk_i and rst_ni in scope; no other dependencies
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked at every rising edge out of reset
`define SIPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sipq assertion failed");

// next-cycle implication
`define SIPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sipq assertion failed");

`else

`define SIPQ_ASSERT_IMPL(label, ante, cons)
`define SIPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/sipq_pkg.sv
// shared constants and types for the sorted insert priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sipq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam logic FUNC_STORE    = 1'b0;
  localparam logic FUNC_RETRIEVE = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   remove;
    value_t value;
  } cell_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    value_t value;
    logic   le;
  } cell_link_t;

endpackage

`default_nettype wire

>>> sv/sipq_in_if.sv
// input channel of the sorted insert priority queue
// depends on sipq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sipq_in_if;
  import sipq_pkg::*;

  logic   valid;
  logic   ready;
  logic   func;
  value_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);

endinterface

`default_nettype wire

>>> sv/sipq_out_if.sv
// result channel of the sorted insert priority queue
// depends on sipq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sipq_out_if;
  import sipq_pkg::*;

  logic   valid;
  logic   ready;
  value_t result_value;
  logic   was_empty;
  logic   was_full;

  modport source (output valid, output result_value, output was_empty, output was_full,
                  input ready);
  modport sink   (input valid, input result_value, input was_empty, input was_full,
                  output ready);

endinterface

`default_nettype wire

>>> sv/sipq_cell.sv
// one compare-and-shift cell of the sorted chain
// depends on sipq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sipq_cell (
  input  wire logic                 clk_i,
  input  wire sipq_pkg::cell_op_t   op_i,
  input  wire logic                 occupied_i,
  input  wire sipq_pkg::cell_link_t left_i,
  input  wire sipq_pkg::value_t     right_value_i,
  output sipq_pkg::cell_link_t      link_o
);
  import sipq_pkg::*;

  value_t held_q, held_d;
  logic   le;

  // held entry stays ahead of the new value when it is less or equal
  assign le = occupied_i && (held_q <= op_i.value);

  always_comb begin
    held_d = held_q;
    if (op_i.insert) begin
      if (le) begin
        held_d = held_q;
      end else if (left_i.le) begin
        held_d = op_i.value;
      end else begin
        held_d = left_i.value;
      end
    end else if (op_i.remove) begin
      held_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  assign link_o.value = held_q;
  assign link_o.le    = le;

endmodule

`default_nettype wire

>>> sv/sorted_insert_priority_queue.sv
// Sorted priority queue of up to sipq_pkg::DEPTH signed values, smallest first; equal values
// leave in arrival order. For each transaction all cells compare their entry with the
// incoming value at once and the chain shifts by one place, so a new transaction is taken in
// every cycle in which the result register is empty or being read. Each transaction gives
// one registered result, valid in the cycle after it is taken. The occupancy count and the
// result valid flag are the only state that reset clears.
// depends on sipq_pkg, sipq_in_if, sipq_out_if, sipq_cell and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sipq_in_if.sink      in_i,
  sipq_out_if.source   out_o
);
  import sipq_pkg::*;

  cnt_t       count_q, count_d;
  logic       out_valid_q;
  value_t     res_q, res_d;
  logic       empty_q, empty_d;
  logic       full_q, full_d;
  logic       accept;
  logic       is_full, is_empty;
  logic       store_dropped;
  cell_op_t   op;
  cell_link_t link_w [DEPTH];
  cell_link_t head_link;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q == cnt_t'(DEPTH));
  assign is_empty   = (count_q == '0);

  assign op.insert = accept && (in_i.func == FUNC_STORE) && !is_full;
  assign op.remove = accept && (in_i.func == FUNC_RETRIEVE) && !is_empty;
  assign op.value  = in_i.value;

  assign store_dropped = accept && (in_i.func == FUNC_STORE) && is_full;

  // the head cell always lets the new value in ahead of an unoccupied spot
  assign head_link.value = '0;
  assign head_link.le    = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_w;
    value_t     right_w;
    logic       occ_w;

    assign occ_w = (cnt_t'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_w = head_link;
    end else begin : g_mid
      assign left_w = link_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = link_w[i+1].value;
    end

    sipq_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .occupied_i    (occ_w),
      .left_i        (left_w),
      .right_value_i (right_w),
      .link_o        (link_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.insert) begin
      count_d = count_q + cnt_t'(1);
    end else if (op.remove) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  always_comb begin
    res_d   = '0;
    empty_d = 1'b0;
    full_d  = 1'b0;
    case (in_i.func)
      FUNC_STORE: begin
        full_d = is_full;
      end
      FUNC_RETRIEVE: begin
        empty_d = is_empty;
        if (!is_empty) begin
          res_d = link_w[0].value;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q   <= res_d;
      empty_q <= empty_d;
      full_q  <= full_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res_q;
  assign out_o.was_empty    = empty_q;
  assign out_o.was_full     = full_q;

  `SIPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= cnt_t'(DEPTH))
  `SIPQ_ASSERT_NEXT(a_full_store_holds, store_dropped, count_q == $past(count_q))
  `SIPQ_ASSERT_NEXT(a_result_follows, accept, out_valid_q)
  `SIPQ_ASSERT_IMPL(a_empty_flag_clean, out_valid_q && empty_q, res_q == '0 && !full_q)
  `SIPQ_ASSERT_NEXT(a_retrieve_drops_one, op.remove, count_q == $past(count_q) - cnt_t'(1))

endmodule

`default_nettype wire

>>> tb/tb_sorted_insert_priority_queue.sv
// testbench for sorted_insert_priority_queue: a directed table, then random store/retrieve
// traffic with random idling on both channels, every result checked against a sorted shadow
// queue or a typed row's result; depends on sipq_pkg, sipq_in_if, sipq_out_if and the block
`timescale 1ns / 1ps

module tb_sorted_insert_priority_queue;
  import sipq_pkg::*;

  localparam int     RANDOM_ITEMS   = 1400;
  localparam int     QUIET_START    = 1216;  // no idling on either side from here on
  localparam int     HOLD_AT_ITEM   = 400;
  localparam int     LONG_HOLD      = 120;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     NUM_ROWS       = 25;
  localparam value_t VAL_MAX        = value_t'(32'h7fff_ffff);
  localparam value_t VAL_MIN        = value_t'(32'h8000_0000);

  typedef struct packed {
    value_t result_value;
    logic   was_empty;
    logic   was_full;
  } pq_result_t;

  typedef struct packed {
    logic       func;
    value_t     value;
    logic       typed;     // row carries its own expected result
    pq_result_t result;
  } stim_row_t;

  localparam pq_result_t NO_RES = '0;

  logic clk_i;
  logic rst_ni;

  sipq_in_if  in_ch ();
  sipq_out_if out_ch ();

  sorted_insert_priority_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  value_t     sorted_shadow[$];
  pq_result_t pending_results[$];
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  bit         idle_on        = 1'b1;
  bit         stall_on       = 1'b1;
  bit         long_hold_req  = 1'b0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{FUNC_RETRIEVE, value_t'(0),            1'b1, '{value_t'(0), 1'b1, 1'b0}},
    '{FUNC_STORE,    VAL_MAX,                1'b0, NO_RES},
    '{FUNC_STORE,    VAL_MIN,                1'b0, NO_RES},
    '{FUNC_RETRIEVE, value_t'(0),            1'b1, '{VAL_MIN, 1'b0, 1'b0}},
    '{FUNC_RETRIEVE, value_t'(0),            1'b1, '{VAL_MAX, 1'b0, 1'b0}},
    '{FUNC_RETRIEVE, value_t'(32'h1234_5678), 1'b1, '{value_t'(0), 1'b1, 1'b0}},
    '{FUNC_STORE,    value_t'(32'haaaa_aaaa), 1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(32'h5555_5555), 1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(-1),           1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(1),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(5),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(5),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(-5),           1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(0),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(100),          1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(-100),         1'b0, NO_RES},
    '{FUNC_STORE,    VAL_MAX,                1'b0, NO_RES},
    '{FUNC_STORE,    VAL_MIN,                1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(3),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(3),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(-2),           1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(2),            1'b0, NO_RES},
    '{FUNC_STORE,    value_t'(7),            1'b1, '{value_t'(0), 1'b0, 1'b1}},
    '{FUNC_RETRIEVE, value_t'(0),            1'b1, '{VAL_MIN, 1'b0, 1'b0}},
    '{FUNC_RETRIEVE, value_t'(-1),           1'b0, NO_RES}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // shadow of the queue contents, kept ascending; equal values stay in arrival order
  function automatic pq_result_t predict_queue_op(input logic op, input value_t val);
    pq_result_t r;
    int         pos;
    r = '0;
    if (op == FUNC_STORE) begin
      if (sorted_shadow.size() >= DEPTH) begin
        r.was_full = 1'b1;
      end else begin
        pos = 0;
        while (pos < sorted_shadow.size() && sorted_shadow[pos] <= val) pos++;
        sorted_shadow.insert(pos, val);
      end
    end else if (sorted_shadow.size() == 0) begin
      r.was_empty = 1'b1;
    end else begin
      r.result_value = sorted_shadow.pop_front();
    end
    return r;
  endfunction

  function automatic value_t rand_value();
    value_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = value_t'(int'($urandom_range(0, 16)) - 8);  // many duplicates
      4: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = value_t'(0);
          default: v = value_t'(-1);
        endcase
      end
      default: v = value_t'($urandom());
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string field, input value_t got, input value_t want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // offer one transaction, wait for it to be taken, then record what must come back
  task automatic send_item(input logic op, input value_t val, input logic typed,
                           input pq_result_t typed_res);
    pq_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= op;
    in_ch.value <= val;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    predicted = predict_queue_op(op, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // result side
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pq_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", out_ch.result_value,
                        value_t'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_value !== want.result_value)
          report_mismatch("result_value", out_ch.result_value, want.result_value);
        if (out_ch.was_empty !== want.was_empty)
          report_mismatch("was_empty", value_t'(out_ch.was_empty), value_t'(want.was_empty));
        if (out_ch.was_full !== want.was_full)
          report_mismatch("was_full", value_t'(out_ch.was_full), value_t'(want.was_full));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int   n;
    int   store_pct;
    logic op;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func  = FUNC_STORE;
    in_ch.value = '0;
    store_pct   = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].result);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // segments lean toward filling, draining or balance so full and empty both get hit
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       store_pct = 20;
          1:       store_pct = 50;
          default: store_pct = 85;
        endcase
        idle_on  = (n < QUIET_START) && ($urandom_range(0, 2) != 0);
        stall_on = (n < QUIET_START) && ($urandom_range(0, 2) != 0);
      end
      if (n == HOLD_AT_ITEM) long_hold_req = 1'b1;
      op = ($urandom_range(1, 100) <= store_pct) ? FUNC_STORE : FUNC_RETRIEVE;
      send_item(op, rand_value(), 1'b0, NO_RES);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
